// ----- rtl/bitmap_frame_allocator_assert.svh -----
// Assertion macros used by the frame allocator controller.
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define BFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame allocator check failed");

`define BFA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame allocator check failed");

`else

`define BFA_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define BFA_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/bfa_pkg.sv -----
// Shared types, constants and command structures of the frame allocator.
`default_nettype none

package bfa_pkg;

   localparam int FRAME_W        = 12;
   localparam int WORD_W         = 32;
   localparam int BIT_W          = 5;
   localparam int WIDX_W         = FRAME_W - BIT_W;
   localparam int FC_W           = 13;
   localparam int FRAME_SPAN     = 4096;
   localparam int SPAN_WORDS     = FRAME_SPAN / WORD_W;
   localparam int MAX_FRAMES_DEF = 4096;
   localparam logic [FC_W-1:0] FC_RESET = 13'd4096;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_NOTHING = 2'd1,
      STAT_OOF     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_FREE_WR,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_NEXT,
      RD_FREE
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_CLEAR,
      WR_MARK,
      WR_FREE
   } wr_sel_type;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       set_status;
      status_type status;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_free;
      logic cur_zero;
      logic word_full;
      logic hit_ok;
      logic next_ok;
      logic free_ok;
   } flags_type;

endpackage

`default_nettype wire

// ----- rtl/bfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/bfa_dp.sv -----
// Datapath of the frame allocator: request registers, bitmap RAM, scan and result registers.
`default_nettype none

module bfa_dp #(
   parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bfa_pkg::cmd_type                  cmd,
   output bfa_pkg::flags_type                     flags,
   input  wire logic                              req_opcode,
   input  wire logic [bfa_pkg::FRAME_W-1:0]       req_current_frame,
   input  wire logic                              req_kernel_only,
   input  wire logic                              req_may_write,
   input  wire logic                              csr_wr_en,
   input  wire logic [bfa_pkg::FC_W-1:0]          csr_wr_data,
   output logic      [bfa_pkg::FRAME_W-1:0]       rsp_frame_number,
   output logic                                   rsp_present,
   output logic                                   rsp_writable,
   output logic                                   rsp_user_access,
   output logic      [1:0]                        rsp_status
);

   localparam int WORDS     = (MAX_FRAMES + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W;
   localparam int BM_DEPTH  = (WORDS < bfa_pkg::SPAN_WORDS) ? WORDS : bfa_pkg::SPAN_WORDS;
   localparam int ADDR_W    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
   localparam int WIDX1_W   = bfa_pkg::WIDX_W + 1;
   localparam int LIM_CAP_I = (MAX_FRAMES < bfa_pkg::FRAME_SPAN) ? MAX_FRAMES
                                                                 : bfa_pkg::FRAME_SPAN;
   localparam logic [bfa_pkg::FC_W-1:0] LIM_CAP = bfa_pkg::FC_W'(LIM_CAP_I);
   localparam logic [WIDX1_W-1:0]       DEPTH_L = WIDX1_W'(BM_DEPTH);
   localparam logic [ADDR_W-1:0]        LAST_A  = ADDR_W'(BM_DEPTH - 1);

   logic [bfa_pkg::FC_W-1:0]     frame_count_ff;
   bfa_pkg::op_type              opcode_ff;
   logic [bfa_pkg::FRAME_W-1:0]  cur_ff;
   logic                         kernel_only_ff;
   logic                         may_write_ff;
   logic [ADDR_W-1:0]            ptr_ff;
   logic [ADDR_W-1:0]            clr_ptr_ff;
   logic [bfa_pkg::FRAME_W-1:0]  found_ff;
   bfa_pkg::status_type          status_ff;
   logic [bfa_pkg::FRAME_W-1:0]  rsp_frame_number_ff;
   logic                         rsp_present_ff;
   logic                         rsp_writable_ff;
   logic                         rsp_user_access_ff;
   bfa_pkg::status_type          rsp_status_ff;

   logic [bfa_pkg::FRAME_W-1:0]  frame_in;
   logic                         alloc_ok;
   logic [bfa_pkg::FC_W-1:0]     lim;
   logic [bfa_pkg::BIT_W-1:0]    zero_pos;
   logic [bfa_pkg::FRAME_W-1:0]  found_cand;
   logic [WIDX1_W-1:0]           nxt_idx;
   logic [bfa_pkg::WIDX_W-1:0]   free_idx;
   logic [ADDR_W-1:0]            rd_addr;
   logic [ADDR_W-1:0]            wr_addr;
   logic [bfa_pkg::WORD_W-1:0]   wr_data;
   logic [bfa_pkg::WORD_W-1:0]   rd_data;

   always_comb begin
      zero_pos = '0;
      for (int i = bfa_pkg::WORD_W - 1; i >= 0; i--) begin
         if (!rd_data[i]) begin
            zero_pos = bfa_pkg::BIT_W'(i);
         end
      end
   end

   assign lim        = (frame_count_ff < LIM_CAP) ? frame_count_ff : LIM_CAP;
   assign found_cand = {bfa_pkg::WIDX_W'(ptr_ff), zero_pos};
   assign nxt_idx    = {1'b0, bfa_pkg::WIDX_W'(ptr_ff)} + WIDX1_W'(1);
   assign free_idx   = cur_ff[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];

   assign flags.clr_last  = (clr_ptr_ff == LAST_A);
   assign flags.is_free   = (opcode_ff == bfa_pkg::OP_FREE);
   assign flags.cur_zero  = (cur_ff == '0);
   assign flags.word_full = &rd_data;
   assign flags.hit_ok    = ({1'b0, found_cand} < lim);
   assign flags.next_ok   = (nxt_idx < DEPTH_L) && ({nxt_idx, {bfa_pkg::BIT_W{1'b0}}} < lim);
   assign flags.free_ok   = ({1'b0, free_idx} < DEPTH_L);

   always_comb begin
      case (cmd.rd_sel)
         bfa_pkg::RD_ZERO: rd_addr = '0;
         bfa_pkg::RD_NEXT: rd_addr = ptr_ff + ADDR_W'(1);
         bfa_pkg::RD_FREE: rd_addr = ADDR_W'(free_idx);
         default:          rd_addr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         bfa_pkg::WR_CLEAR: begin
            wr_addr = clr_ptr_ff;
            wr_data = '0;
         end
         bfa_pkg::WR_MARK: begin
            wr_addr = ptr_ff;
            wr_data = rd_data | (bfa_pkg::WORD_W'(1) << zero_pos);
         end
         bfa_pkg::WR_FREE: begin
            wr_addr = ADDR_W'(free_idx);
            wr_data = rd_data & ~(bfa_pkg::WORD_W'(1) << cur_ff[bfa_pkg::BIT_W-1:0]);
         end
         default: begin
            wr_addr = clr_ptr_ff;
            wr_data = '0;
         end
      endcase
   end

   bfa_ram #(
      .WIDTH (bfa_pkg::WORD_W),
      .DEPTH (BM_DEPTH)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= bfa_pkg::FC_RESET;
         clr_ptr_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            frame_count_ff <= csr_wr_data;
         end
         if (cmd.wr_en && (cmd.wr_sel == bfa_pkg::WR_CLEAR)) begin
            clr_ptr_ff <= clr_ptr_ff + ADDR_W'(1);
         end
      end
   end

   assign alloc_ok = (opcode_ff == bfa_pkg::OP_ALLOC) && (status_ff == bfa_pkg::STAT_DONE);

   always_comb begin
      if (opcode_ff == bfa_pkg::OP_FREE) begin
         frame_in = '0;
      end else begin
         case (status_ff)
            bfa_pkg::STAT_DONE:    frame_in = found_ff;
            bfa_pkg::STAT_NOTHING: frame_in = cur_ff;
            default:               frame_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff      <= bfa_pkg::op_type'(req_opcode);
         cur_ff         <= req_current_frame;
         kernel_only_ff <= req_kernel_only;
         may_write_ff   <= req_may_write;
      end
      if (cmd.rd_en) begin
         case (cmd.rd_sel)
            bfa_pkg::RD_ZERO: ptr_ff <= '0;
            bfa_pkg::RD_NEXT: ptr_ff <= ptr_ff + ADDR_W'(1);
            default:          ptr_ff <= ptr_ff;
         endcase
      end
      if (cmd.wr_en && (cmd.wr_sel == bfa_pkg::WR_MARK)) begin
         found_ff <= found_cand;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.load_out) begin
         rsp_frame_number_ff <= frame_in;
         rsp_present_ff      <= alloc_ok;
         rsp_writable_ff     <= alloc_ok & may_write_ff;
         rsp_user_access_ff  <= alloc_ok & ~kernel_only_ff;
         rsp_status_ff       <= status_ff;
      end
   end

   assign rsp_frame_number = rsp_frame_number_ff;
   assign rsp_present      = rsp_present_ff;
   assign rsp_writable     = rsp_writable_ff;
   assign rsp_user_access  = rsp_user_access_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// ----- rtl/bfa_ctrl.sv -----
// Controller state machine of the frame allocator and the result valid register.
`default_nettype none

`include "bitmap_frame_allocator_assert.svh"

module bfa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire bfa_pkg::flags_type flags,
   output bfa_pkg::cmd_type        cmd
);

   bfa_pkg::state_type state_ff;
   bfa_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfa_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         bfa_pkg::S_CLEAR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bfa_pkg::WR_CLEAR;
            if (flags.clr_last) begin
               state_in = bfa_pkg::S_IDLE;
            end
         end
         bfa_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = bfa_pkg::S_DISPATCH;
            end
         end
         bfa_pkg::S_DISPATCH: begin
            if (!flags.is_free) begin
               if (!flags.cur_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = bfa_pkg::STAT_NOTHING;
                  state_in       = bfa_pkg::S_DONE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = bfa_pkg::RD_ZERO;
                  state_in   = bfa_pkg::S_SCAN;
               end
            end else if (flags.cur_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = bfa_pkg::STAT_NOTHING;
               state_in       = bfa_pkg::S_DONE;
            end else if (flags.free_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bfa_pkg::RD_FREE;
               state_in   = bfa_pkg::S_FREE_WR;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = bfa_pkg::STAT_DONE;
               state_in       = bfa_pkg::S_DONE;
            end
         end
         bfa_pkg::S_SCAN: begin
            if (!flags.word_full) begin
               cmd.set_status = 1'b1;
               if (flags.hit_ok) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = bfa_pkg::WR_MARK;
                  cmd.status = bfa_pkg::STAT_DONE;
               end else begin
                  cmd.status = bfa_pkg::STAT_OOF;
               end
               state_in = bfa_pkg::S_DONE;
            end else if (flags.next_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bfa_pkg::RD_NEXT;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = bfa_pkg::STAT_OOF;
               state_in       = bfa_pkg::S_DONE;
            end
         end
         bfa_pkg::S_FREE_WR: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_sel     = bfa_pkg::WR_FREE;
            cmd.set_status = 1'b1;
            cmd.status     = bfa_pkg::STAT_DONE;
            state_in       = bfa_pkg::S_DONE;
         end
         bfa_pkg::S_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = bfa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bfa_pkg::S_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BFA_ASSERT_NXT(a_accept_dispatch, clock, reset, req_valid && !req_stall, state_ff == bfa_pkg::S_DISPATCH)
   `BFA_ASSERT_NXT(a_scan_continues, clock, reset, (state_ff == bfa_pkg::S_SCAN) && flags.word_full && flags.next_ok, state_ff == bfa_pkg::S_SCAN)
   `BFA_ASSERT_NXT(a_free_completes, clock, reset, state_ff == bfa_pkg::S_FREE_WR, state_ff == bfa_pkg::S_DONE)
   `BFA_ASSERT_NXT(a_done_delivers, clock, reset, (state_ff == bfa_pkg::S_DONE) && !rsp_valid_ff, rsp_valid_ff && (state_ff == bfa_pkg::S_IDLE))

endmodule

`default_nettype wire

// ----- rtl/bitmap_frame_allocator.sv -----
// Top level of the first-fit bitmap physical frame allocator.
//
//   Channel   Direction  Handshake              Fields
//   req       in         req_valid/req_stall    opcode, current_frame, kernel_only, may_write
//   rsp       out        rsp_valid/rsp_stall    frame_number, present, writable, user_access, status
//   csr       in         csr_wr_en              frame_count (13 bits)
//
// A free within the bitmap: dispatch, bitmap read and write, done; nothing to do, other frees: dispatch to done.
// An allocate request with current_frame zero reads bitmap words from word 0 until a free bit or the limit is found
// (at most 128): the scan reads one 32-bit word per cycle through the bitmap RAM read port.
// After reset the bitmap RAM is cleared one word per cycle, 128 words at the default size,
// while requests are stalled; CSR writes are taken at any time.
// A finished result waits until the output register is free; a new request is then accepted.
`default_nettype none

module bitmap_frame_allocator #(
   parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_opcode,
   input  wire logic [bfa_pkg::FRAME_W-1:0] req_current_frame,
   input  wire logic                        req_kernel_only,
   input  wire logic                        req_may_write,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [bfa_pkg::FRAME_W-1:0] rsp_frame_number,
   output logic                             rsp_present,
   output logic                             rsp_writable,
   output logic                             rsp_user_access,
   output logic      [1:0]                  rsp_status,
   input  wire logic                        csr_wr_en,
   input  wire logic [bfa_pkg::FC_W-1:0]    csr_wr_data
);

   bfa_pkg::cmd_type   cmd;
   bfa_pkg::flags_type flags;

   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   bfa_dp #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .flags             (flags),
      .req_opcode        (req_opcode),
      .req_current_frame (req_current_frame),
      .req_kernel_only   (req_kernel_only),
      .req_may_write     (req_may_write),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_present       (rsp_present),
      .rsp_writable      (rsp_writable),
      .rsp_user_access   (rsp_user_access),
      .rsp_status        (rsp_status)
   );

endmodule

`default_nettype wire

// ----- test/bitmap_frame_allocator_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the first-fit bitmap frame allocator with random request traffic.
module bitmap_frame_allocator_tb;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 140;

   typedef struct packed {
      logic [bfa_pkg::FRAME_W-1:0] frame_number;
      logic                        present;
      logic                        writable;
      logic                        user_access;
      bfa_pkg::status_type         status;
   } entry_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_opcode = bfa_pkg::OP_ALLOC;
   logic [bfa_pkg::FRAME_W-1:0] req_current_frame = '0;
   logic                        req_kernel_only = 1'b0;
   logic                        req_may_write = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [bfa_pkg::FRAME_W-1:0] rsp_frame_number;
   logic                        rsp_present;
   logic                        rsp_writable;
   logic                        rsp_user_access;
   logic [1:0]                  rsp_status;
   logic                        csr_wr_en = 1'b0;
   logic [bfa_pkg::FC_W-1:0]    csr_wr_data = '0;

   logic [bfa_pkg::FRAME_SPAN-1:0] frame_used = '0;
   logic [bfa_pkg::FC_W-1:0]       managed_count = bfa_pkg::FC_RESET;
   entry_result_type               expected_entries[$];
   logic [bfa_pkg::FRAME_W-1:0]    held_frames[$];

   bit idle_on = 1'b1;
   int stall_left = 0;
   int hold_off = 0;
   int quiet_cycles = 0;
   int failures = 0;

   bitmap_frame_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_current_frame (req_current_frame),
      .req_kernel_only   (req_kernel_only),
      .req_may_write     (req_may_write),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_present       (rsp_present),
      .rsp_writable      (rsp_writable),
      .rsp_user_access   (rsp_user_access),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   // First-fit allocation and frees over the frame bitmap, updated as the block should.
   function automatic entry_result_type predict_entry(input bfa_pkg::op_type op,
                                                      input logic [bfa_pkg::FRAME_W-1:0] cur,
                                                      input logic kernel, input logic wr);
      entry_result_type r;
      int limit;
      r = '0;
      r.status = bfa_pkg::STAT_DONE;
      limit = (managed_count > bfa_pkg::FRAME_SPAN) ? bfa_pkg::FRAME_SPAN
                                                    : int'(managed_count);
      if (op == bfa_pkg::OP_ALLOC) begin
         if (cur != '0) begin
            r.frame_number = cur;
            r.status = bfa_pkg::STAT_NOTHING;
         end else begin
            r.status = bfa_pkg::STAT_OOF;
            for (int f = 0; f < limit; f++) begin
               if (!frame_used[f]) begin
                  frame_used[f] = 1'b1;
                  r.frame_number = f[bfa_pkg::FRAME_W-1:0];
                  r.present = 1'b1;
                  r.writable = wr;
                  r.user_access = ~kernel;
                  r.status = bfa_pkg::STAT_DONE;
                  break;
               end
            end
         end
      end else if (cur == '0) begin
         r.status = bfa_pkg::STAT_NOTHING;
      end else begin
         frame_used[cur] = 1'b0;
      end
      return r;
   endfunction

   task automatic send_request(input bfa_pkg::op_type op,
                               input logic [bfa_pkg::FRAME_W-1:0] cur,
                               input logic kernel, input logic wr);
      int gap;
      entry_result_type r;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_current_frame <= cur;
      req_kernel_only <= kernel;
      req_may_write <= wr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = predict_entry(op, cur, kernel, wr);
      expected_entries.push_back(r);
      if (op == bfa_pkg::OP_ALLOC && r.status == bfa_pkg::STAT_DONE)
         held_frames.push_back(r.frame_number);
   endtask

   task automatic wait_for_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
   endtask

   task automatic write_frame_count(input logic [bfa_pkg::FC_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      managed_count = value;
   endtask

   task automatic send_random_request(input int alloc_pct);
      int pick;
      int idx;
      logic [bfa_pkg::FRAME_W-1:0] frame;
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
         send_request(bfa_pkg::OP_ALLOC, '0, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end else if (pick < 88 && held_frames.size() > 0) begin
         idx = $urandom_range(0, held_frames.size() - 1);
         frame = held_frames[idx];
         held_frames.delete(idx);
         send_request(bfa_pkg::OP_FREE, frame, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end else begin
         frame = bfa_pkg::FRAME_W'($urandom_range(0, bfa_pkg::FRAME_SPAN - 1));
         if ($urandom_range(0, 3) == 0) frame = '0;
         send_request(bfa_pkg::op_type'($urandom_range(0, 1)), frame,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_phase(input logic [bfa_pkg::FC_W-1:0] count_value, input int requests,
                            input int alloc_pct, input bit with_idle);
      wait_for_results();
      write_frame_count(count_value);
      idle_on = with_idle;
      held_frames.delete();
      for (int f = 0; f < bfa_pkg::FRAME_SPAN; f++)
         if (frame_used[f] && f != 0) held_frames.push_back(f[bfa_pkg::FRAME_W-1:0]);
      for (int n = 0; n < requests; n++) send_random_request(alloc_pct);
   endtask

   // Default size after reset: frame zero first, nothing-to-do cases and field extremes.
   task automatic test_basic_entries;
      send_request(bfa_pkg::OP_ALLOC, '0, 1'b0, 1'b1);
      send_request(bfa_pkg::OP_ALLOC, '0, 1'b1, 1'b0);
      send_request(bfa_pkg::OP_ALLOC, 12'hFFF, 1'b1, 1'b1);
      send_request(bfa_pkg::OP_FREE, '0, 1'b0, 1'b0);
      send_request(bfa_pkg::OP_FREE, 12'd1, 1'b0, 1'b0);
      send_request(bfa_pkg::OP_ALLOC, '0, 1'b1, 1'b1);
      send_request(bfa_pkg::OP_FREE, 12'hFFF, 1'b0, 1'b1);
      send_request(bfa_pkg::OP_FREE, '0, 1'b1, 1'b1);
   endtask

   // Out of frames, an empty pool, counts past the frame span and a lowered limit.
   task automatic test_frame_limits;
      wait_for_results();
      write_frame_count(13'd2);
      send_request(bfa_pkg::OP_ALLOC, '0, 1'b0, 1'b0);
      send_request(bfa_pkg::OP_FREE, 12'd0, 1'b0, 1'b0);
      send_request(bfa_pkg::OP_FREE, 12'd1, 1'b0, 1'b0);
      send_request(bfa_pkg::OP_ALLOC, '0, 1'b0, 1'b1);
      wait_for_results();
      write_frame_count(13'd0);
      send_request(bfa_pkg::OP_ALLOC, '0, 1'b1, 1'b1);
      wait_for_results();
      write_frame_count(13'h1FFF);
      send_request(bfa_pkg::OP_ALLOC, '0, 1'b0, 1'b1);
      send_request(bfa_pkg::OP_ALLOC, '0, 1'b1, 1'b0);
      wait_for_results();
      write_frame_count(13'd1);
      send_request(bfa_pkg::OP_FREE, 12'd3000, 1'b0, 1'b0);
      send_request(bfa_pkg::OP_ALLOC, '0, 1'b0, 1'b0);
      send_request(bfa_pkg::OP_FREE, 12'd2, 1'b0, 1'b0);
      wait_for_results();
      write_frame_count(13'd3);
      send_request(bfa_pkg::OP_ALLOC, '0, 1'b0, 1'b1);
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_output_backpressure;
      wait_for_results();
      write_frame_count(bfa_pkg::FC_RESET);
      idle_on = 1'b0;
      hold_off = HOLD_CYCLES;
      for (int n = 0; n < 12; n++) send_random_request(60);
      wait_for_results();
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic;
      run_phase(13'd40, 500, 60, 1'b1);
      run_phase(13'd33, 200, 55, 1'b0);
      run_phase(13'd4096, 400, 60, 1'b1);
      run_phase(13'h1FFF, 250, 50, 1'b1);
      run_phase(13'd0, 100, 50, 1'b1);
      run_phase(13'd200, 450, 65, 1'b1);
   endtask

   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            stall_left = hold_off;
            hold_off = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      entry_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_entries.size() == 0) begin
            $error("response with no request outstanding: frame_number %0d status %0d",
                   rsp_frame_number, rsp_status);
            failures++;
         end else begin
            e = expected_entries.pop_front();
            if (rsp_frame_number !== e.frame_number) begin
               $error("frame_number expected %0d actual %0d", e.frame_number, rsp_frame_number);
               failures++;
            end
            if (rsp_present !== e.present) begin
               $error("present expected %0d actual %0d", e.present, rsp_present);
               failures++;
            end
            if (rsp_writable !== e.writable) begin
               $error("writable expected %0d actual %0d", e.writable, rsp_writable);
               failures++;
            end
            if (rsp_user_access !== e.user_access) begin
               $error("user_access expected %0d actual %0d", e.user_access, rsp_user_access);
               failures++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               failures++;
            end
         end
         stall_left = idle_on ? $urandom_range(0, 7) : 0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_entries();
      test_frame_limits();
      test_output_backpressure();
      test_random_traffic();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_entries.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
